// ===== hw/rtl/delayed_and_periodic_message_scheduler_assert.svh =====
// Assertion macros for the message scheduler
`ifndef DELAYED_AND_PERIODIC_MESSAGE_SCHEDULER_ASSERT_SVH
`define DELAYED_AND_PERIODIC_MESSAGE_SCHEDULER_ASSERT_SVH
`ifndef SYNTH
`define DPMS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DPMS_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPMS_ASSERT(label, clk, rst, prop, msg)
`define DPMS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/dpms_pkg.sv =====
// ----------------------------------------------------------------------------
// dpms_pkg
// Types and constants shared by the message scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none
package dpms_pkg;
  localparam int REPLY_DEPTH = 16;
  localparam int GEN_DEPTH   = 16;
  localparam int MAX_OUT     = 32;

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_SCHEDULE = 3'd1;
  localparam logic [2:0] REQ_START    = 3'd2;
  localparam logic [2:0] REQ_STOP     = 3'd3;
  localparam logic [2:0] REQ_CANCEL   = 3'd4;

  localparam logic [1:0] ST_DELIVER = 2'd0;
  localparam logic [1:0] ST_ACCEPT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [0:0] REG_INSTANT = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE, S_REPLY, S_GEN, S_CLEAR, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, advance time on tick
    logic rp_start;  // begin reply scan
    logic step;      // advance current scan by one entry
    logic ack;       // build acknowledge result
    logic out_take;  // output register consumed
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;   // current scan finished
    logic out_full;    // output register holds a result
  } stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/delayed_and_periodic_message_scheduler.sv =====
// ----------------------------------------------------------------------------
// delayed_and_periodic_message_scheduler
// Timer scheduler with one-shot reply and periodic generator tables.
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// request  | in        | in_valid/in_stall  | req_type, channel_id, msg_handle, delay
// result   | out       | out_valid/out_stall| out_channel, out_handle, from_periodic,
//          |           |                    | status, last
// config   | in        | APB                | instant_mode at 0
// A tick walks the reply table then the generator table, one entry a cycle while
// no held result is stalled.
// Schedule and start acknowledge directly; stop and cancel first compact their table.
// rst is synchronous and clears counts, time and the sequencer.
// out_stall freezes the scan while a result is held.
`default_nettype none
module delayed_and_periodic_message_scheduler #(
  parameter int REPLY_DEPTH = dpms_pkg::REPLY_DEPTH,
  parameter int GEN_DEPTH   = dpms_pkg::GEN_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] channel_id,
  input  wire logic [7:0]  msg_handle,
  input  wire logic [15:0] delay_or_interval_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_channel,
  output logic [7:0]       out_handle,
  output logic             from_periodic,
  output logic [1:0]       status,
  output logic             last
);
  dpms_pkg::cmd_t  cmd;
  dpms_pkg::stat_t stat;
  logic instant_mode;

  assign pready = 1'b1;
  assign prdata = (paddr == dpms_pkg::REG_INSTANT) ? {31'd0, instant_mode} : 32'd0;

  // config register
  always_ff @(posedge clk) begin
    if (rst) instant_mode <= 1'b0;
    else if (psel && penable && pwrite && paddr == dpms_pkg::REG_INSTANT)
      instant_mode <= pwdata[0];
  end

  dpms_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .req_type, .out_stall, .out_valid,
    .cmd, .stat
  );

  dpms_datapath #(.REPLY_DEPTH(REPLY_DEPTH), .GEN_DEPTH(GEN_DEPTH)) u_dp (
    .clk, .rst, .cmd, .stat, .instant_mode, .req_type, .channel_id, .msg_handle,
    .delay_or_interval_ms, .out_channel, .out_handle,
    .from_periodic, .status, .last
  );
endmodule
`default_nettype wire

// ===== hw/rtl/dpms_datapath.sv =====
// ----------------------------------------------------------------------------
// dpms_datapath
// Entry tables, time counter, scan pointers and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module dpms_datapath #(
  parameter int REPLY_DEPTH = dpms_pkg::REPLY_DEPTH,
  parameter int GEN_DEPTH   = dpms_pkg::GEN_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dpms_pkg::cmd_t      cmd,
  output dpms_pkg::stat_t          stat,
  input  wire logic                instant_mode,
  input  wire logic [2:0]          req_type,
  input  wire logic [15:0]         channel_id,
  input  wire logic [7:0]          msg_handle,
  input  wire logic [15:0]         delay_or_interval_ms,
  output logic [15:0]              out_channel,
  output logic [7:0]               out_handle,
  output logic                     from_periodic,
  output logic [1:0]               status,
  output logic                     last
);
  localparam int RW = (REPLY_DEPTH > 1) ? $clog2(REPLY_DEPTH) : 1;
  localparam int GW = (GEN_DEPTH > 1) ? $clog2(GEN_DEPTH) : 1;
  localparam int RC = $clog2(REPLY_DEPTH + 1);
  localparam int GC = $clog2(GEN_DEPTH + 1);

  logic [31:0] r_fire [REPLY_DEPTH];
  logic [15:0] r_chan [REPLY_DEPTH];
  logic [7:0]  r_hand [REPLY_DEPTH];
  logic [31:0] g_fire [GEN_DEPTH];
  logic [15:0] g_int  [GEN_DEPTH];
  logic [15:0] g_chan [GEN_DEPTH];
  logic [7:0]  g_hand [GEN_DEPTH];

  logic [31:0] time_ms;
  logic [RC-1:0] reply_count, r_rd, r_wr;
  logic [GC-1:0] gen_count, g_rd, g_wr;
  logic [2:0]  req;
  logic [15:0] ch;
  logic [7:0]  hd;
  logic [15:0] dly;
  logic [5:0]  n_out;
  logic        out_full;

  logic        r_due, g_due, c_keep, r_more, g_more;
  logic        emit, emit_last;
  logic [REPLY_DEPTH-1:0] r_later;
  logic [GEN_DEPTH-1:0]   g_due_all, g_later;

  assign r_more = r_rd < reply_count;
  assign g_more = g_rd < gen_count;
  assign r_due  = r_more && (r_fire[r_rd[RW-1:0]] <= time_ms) && (n_out < 6'd32);
  assign g_due  = g_more && (g_fire[g_rd[GW-1:0]] <= time_ms) && (n_out < 6'd32);
  assign c_keep = (req == dpms_pkg::REQ_STOP) ? (g_chan[g_rd[GW-1:0]] != ch)
                                              : (r_chan[r_rd[RW-1:0]] != ch);
  assign emit = cmd.step && (req == dpms_pkg::REQ_TICK) && (r_more ? r_due : g_due);

  // look ahead for due entries behind the current scan position
  always_comb begin
    for (int i = 0; i < REPLY_DEPTH; i++)
      r_later[i] = (RC'(i) > r_rd) && (RC'(i) < reply_count) && (r_fire[i] <= time_ms);
    for (int i = 0; i < GEN_DEPTH; i++) begin
      g_due_all[i] = (GC'(i) < gen_count) && (g_fire[i] <= time_ms);
      g_later[i]   = g_due_all[i] && (GC'(i) > g_rd);
    end
  end

  // mark the final delivery of a tick
  assign emit_last = (n_out == 6'd31) ||
                     (r_more ? !((|r_later) || (|g_due_all)) : !(|g_later));

  // status toward the controller
  always_comb begin
    stat.out_full = out_full;
    stat.scan_done = 1'b1;
    if (cmd.rp_start) begin
      stat.scan_done = 1'b0;
    end else begin
      unique case (req)
        dpms_pkg::REQ_TICK: begin
          if (r_more) begin
            stat.scan_done = 1'b0;
          end else begin
            stat.scan_done = !g_more;
          end
        end
        dpms_pkg::REQ_STOP: stat.scan_done = !g_more;
        default: stat.scan_done = !r_more;
      endcase
    end
  end

  // hold tables, pointers and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      time_ms <= '0;
      reply_count <= '0;
      gen_count <= '0;
      out_full <= 1'b0;
      r_rd <= '0; r_wr <= '0; g_rd <= '0; g_wr <= '0;
      n_out <= '0;
      req <= '0;
    end else begin
      out_full <= cmd.ack || emit || (out_full && !cmd.out_take);
      if (cmd.load) begin
        req <= req_type; ch <= channel_id; hd <= msg_handle; dly <= delay_or_interval_ms;
        r_rd <= '0; r_wr <= '0; g_rd <= '0; g_wr <= '0; n_out <= '0;
        if (req_type == dpms_pkg::REQ_TICK) time_ms <= time_ms + 32'd1;
      end
      if (cmd.ack) begin
        out_channel <= ch;
        from_periodic <= 1'b0;
        last <= 1'b1;
        out_handle <= ((req == dpms_pkg::REQ_SCHEDULE) || (req == dpms_pkg::REQ_START))
                      ? hd : 8'd0;
        status <= dpms_pkg::ST_ACCEPT;
        if (req == dpms_pkg::REQ_SCHEDULE) begin
          if (reply_count < RC'(REPLY_DEPTH)) begin
            r_fire[reply_count[RW-1:0]] <= time_ms + (instant_mode ? 32'd0 : {16'd0, dly});
            r_chan[reply_count[RW-1:0]] <= ch;
            r_hand[reply_count[RW-1:0]] <= hd;
            reply_count <= reply_count + RC'(1);
          end else status <= dpms_pkg::ST_FULL;
        end else if (req == dpms_pkg::REQ_START) begin
          if (gen_count < GC'(GEN_DEPTH)) begin
            g_fire[gen_count[GW-1:0]] <= time_ms + (instant_mode ? 32'd0 : {16'd0, dly});
            g_int[gen_count[GW-1:0]]  <= dly;
            g_chan[gen_count[GW-1:0]] <= ch;
            g_hand[gen_count[GW-1:0]] <= hd;
            gen_count <= gen_count + GC'(1);
          end else status <= dpms_pkg::ST_FULL;
        end
      end
      if (cmd.step) begin
        if (req == dpms_pkg::REQ_TICK) begin
          if (r_more) begin
            r_rd <= r_rd + RC'(1);
            if (r_due) begin
              out_channel <= r_chan[r_rd[RW-1:0]];
              out_handle <= r_hand[r_rd[RW-1:0]];
              from_periodic <= 1'b0;
              status <= dpms_pkg::ST_DELIVER;
              last <= emit_last;
              n_out <= n_out + 6'd1;
            end else begin
              r_fire[r_wr[RW-1:0]] <= r_fire[r_rd[RW-1:0]];
              r_chan[r_wr[RW-1:0]] <= r_chan[r_rd[RW-1:0]];
              r_hand[r_wr[RW-1:0]] <= r_hand[r_rd[RW-1:0]];
              r_wr <= r_wr + RC'(1);
            end
            if (r_rd + RC'(1) == reply_count)
              reply_count <= r_due ? r_wr : r_wr + RC'(1);
          end else if (g_more) begin
            g_rd <= g_rd + GC'(1);
            if (g_due) begin
              out_channel <= g_chan[g_rd[GW-1:0]];
              out_handle <= g_hand[g_rd[GW-1:0]];
              from_periodic <= 1'b1;
              status <= dpms_pkg::ST_DELIVER;
              last <= emit_last;
              n_out <= n_out + 6'd1;
              g_fire[g_rd[GW-1:0]] <= time_ms + {16'd0, g_int[g_rd[GW-1:0]]};
            end
          end
        end else if (req == dpms_pkg::REQ_STOP) begin
          if (g_more) begin
            g_rd <= g_rd + GC'(1);
            if (c_keep) begin
              g_fire[g_wr[GW-1:0]] <= g_fire[g_rd[GW-1:0]];
              g_int[g_wr[GW-1:0]]  <= g_int[g_rd[GW-1:0]];
              g_chan[g_wr[GW-1:0]] <= g_chan[g_rd[GW-1:0]];
              g_hand[g_wr[GW-1:0]] <= g_hand[g_rd[GW-1:0]];
              g_wr <= g_wr + GC'(1);
            end
          end else gen_count <= g_wr;
        end else begin
          if (r_more) begin
            r_rd <= r_rd + RC'(1);
            if (c_keep) begin
              r_fire[r_wr[RW-1:0]] <= r_fire[r_rd[RW-1:0]];
              r_chan[r_wr[RW-1:0]] <= r_chan[r_rd[RW-1:0]];
              r_hand[r_wr[RW-1:0]] <= r_hand[r_rd[RW-1:0]];
              r_wr <= r_wr + RC'(1);
            end
          end else reply_count <= r_wr;
        end
      end
    end
  end

  `include "delayed_and_periodic_message_scheduler_assert.svh"
  `DPMS_ASSERT(a_rcount, clk, rst, reply_count <= RC'(REPLY_DEPTH), "reply count overflow")
  `DPMS_ASSERT(a_gcount, clk, rst, gen_count <= GC'(GEN_DEPTH), "gen count overflow")
  `DPMS_ASSERT(a_nout, clk, rst, n_out <= 6'd32, "too many results")
endmodule
`default_nettype wire

// ===== hw/rtl/dpms_ctrl.sv =====
// ----------------------------------------------------------------------------
// dpms_ctrl
// Sequencer: take a request, run the table scan, hand results out.
// ----------------------------------------------------------------------------
`default_nettype none
module dpms_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [2:0]      req_type,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output dpms_pkg::cmd_t       cmd,
  input  wire dpms_pkg::stat_t stat
);
  dpms_pkg::state_t state, state_next;
  logic busy;

  assign busy = (state != dpms_pkg::S_IDLE);
  assign out_valid = stat.out_full;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      dpms_pkg::S_IDLE:
        if (in_valid && !stat.out_full) begin
          unique case (req_type)
            dpms_pkg::REQ_TICK: state_next = dpms_pkg::S_REPLY;
            dpms_pkg::REQ_SCHEDULE, dpms_pkg::REQ_START: state_next = dpms_pkg::S_OUT;
            dpms_pkg::REQ_STOP, dpms_pkg::REQ_CANCEL: state_next = dpms_pkg::S_CLEAR;
            default: state_next = dpms_pkg::S_IDLE;
          endcase
        end
      dpms_pkg::S_REPLY: state_next = dpms_pkg::S_GEN;
      dpms_pkg::S_GEN:
        if (stat.scan_done && !stat.out_full) state_next = dpms_pkg::S_IDLE;
      dpms_pkg::S_CLEAR:
        if (stat.scan_done && !stat.out_full) state_next = dpms_pkg::S_OUT;
      dpms_pkg::S_OUT:
        if (!stat.out_full) state_next = dpms_pkg::S_IDLE;
      default: state_next = dpms_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = busy || stat.out_full;
    cmd.out_take = stat.out_full && !out_stall;
    unique case (state)
      dpms_pkg::S_IDLE: cmd.load = in_valid && !stat.out_full;
      dpms_pkg::S_REPLY: cmd.rp_start = 1'b1;
      dpms_pkg::S_GEN: cmd.step = !stat.scan_done && !(stat.out_full && out_stall);
      // keep stepping through the end of the scan so the count gets written back
      dpms_pkg::S_CLEAR: cmd.step = 1'b1;
      dpms_pkg::S_OUT: cmd.ack = !stat.out_full || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= dpms_pkg::S_IDLE;
    else state <= state_next;
  end

  `include "delayed_and_periodic_message_scheduler_assert.svh"
  `DPMS_ASSERT(a_nobusy_take, clk, rst, busy |-> !cmd.load, "load while busy")
  `DPMS_ASSERT(a_ack_once, clk, rst, cmd.ack |=> state == dpms_pkg::S_IDLE, "ack not final")
  `DPMS_ASSERT(a_idle_stall, clk, rst, (state == dpms_pkg::S_GEN) |-> in_stall, "accept in scan")
endmodule
`default_nettype wire
